// ===== rtl/core/dmq_pkg.sv =====
`default_nettype none

package dmq_pkg;

    // Storage geometry
    localparam int DEPTH    = 8;
    localparam int KEY_BITS = 64;

    // Fixed field widths of the channels
    localparam int KEY_W  = 64;
    localparam int HPOS_W = 3;
    localparam int OCC_W  = 4;
    localparam int CAP_W  = 4;

    localparam int CAP_RESET = 8;

    // Derived widths
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // One cycle's access to the entry store
    typedef struct packed {
        logic we;
        idx_t waddr;
        key_t wdata;
        idx_t raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_SH_READ,
        ST_SH_WRITE,
        ST_APPEND,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/dmq_if.sv =====
`default_nettype none

interface dmq_req_if;
    logic                     valid;
    logic                     ready;
    logic [dmq_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface dmq_res_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic [dmq_pkg::HPOS_W-1:0] hit_position;
    logic                      evicted;
    logic [dmq_pkg::KEY_W-1:0]  evicted_key;
    logic [dmq_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, output hit, output hit_position, output evicted,
                    output evicted_key, output occupancy, input ready);
    modport sink   (input valid, input hit, input hit_position, input evicted,
                    input evicted_key, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dmq_store.sv =====
`default_nettype none

module dmq_store (
    input  wire logic              clk,
    input  wire dmq_pkg::mem_req_t mem_req,
    output dmq_pkg::key_t          rdata
);

    dmq_pkg::key_t mem [dmq_pkg::DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[mem_req.raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/dedup_move_to_back_queue_unit.sv =====
`default_nettype none

// Recency list of up to DEPTH keys, oldest at the head. Each request key is
// compared against the stored entries one at a time by a single comparator,
// reading the entry memory through its one registered read port. A hit
// removes the matching entry, a miss with the list at capacity evicts the
// head; in both cases the entries behind close the gap one at a time
// (read, then write back one place closer to the head), and the key is then
// appended at the tail. An item is accepted, each entry is compared, the
// entries behind are moved, the key is appended and the result finishes. A
// hit stops the search at its position and moves the entries behind it; a
// miss that evicts compares every entry and moves all but the head. The
// finish state also waits while the previous result has not been taken.
// The request channel is not ready while an item is in progress; a finished
// result sits in an output register until taken and the next request is
// accepted meanwhile. The user must write the capacity register through
// cfg_write_en and cfg_write_data only while idle; the block itself does
// not enforce this. Capacity 0 or above DEPTH means DEPTH. A capacity
// lowered below the current count evicts only the head on a miss.
module dedup_move_to_back_queue_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write_en,
    input  wire logic [dmq_pkg::CAP_W-1:0]   cfg_write_data,
    dmq_req_if.sink                          request,
    dmq_res_if.source                        result
);

    dmq_pkg::state_t   state_reg, state_next;
    dmq_pkg::key_t     key_reg, key_next;
    dmq_pkg::key_t     head_reg, head_next;
    dmq_pkg::idx_t     idx_reg, idx_next;
    dmq_pkg::idx_t     pos_reg, pos_next;
    dmq_pkg::cnt_t     count_reg, count_next;
    logic              found_reg, found_next;
    logic              ev_reg, ev_next;
    logic [dmq_pkg::CAP_W-1:0] cap_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic [dmq_pkg::HPOS_W-1:0] out_hpos_reg, out_hpos_next;
    logic              out_ev_reg, out_ev_next;
    dmq_pkg::key_t     out_evkey_reg, out_evkey_next;
    dmq_pkg::cnt_t     out_occ_reg, out_occ_next;

    dmq_pkg::mem_req_t mem_req;
    dmq_pkg::key_t     rdata;

    dmq_pkg::cnt_t     eff_cap;
    dmq_pkg::cnt_t     idx_inc;
    logic              match;
    logic              more_search;
    logic              more_shift;
    logic              accept;
    logic              out_free;

    dmq_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    // Capacity 0 or beyond the storage means the full depth
    always_comb
    begin
        if (cap_reg == '0 || 32'(cap_reg) > dmq_pkg::DEPTH)
        begin
            eff_cap = dmq_pkg::CNT_W'(dmq_pkg::DEPTH);
        end
        else
        begin
            eff_cap = dmq_pkg::CNT_W'(cap_reg);
        end
    end

    // The shared compare and index step
    assign match       = (rdata == key_reg);
    assign idx_inc     = dmq_pkg::CNT_W'(idx_reg) + dmq_pkg::CNT_W'(1);
    assign more_search = (idx_inc < count_reg);
    assign more_shift  = ((idx_inc + dmq_pkg::CNT_W'(1)) < count_reg);

    // Take a new request only while idle
    assign request.ready = (state_reg == dmq_pkg::ST_IDLE);

    assign accept   = request.valid && request.ready;
    assign out_free = !out_valid_reg || result.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (count_reg == '0) ? dmq_pkg::ST_APPEND : dmq_pkg::ST_READ;
                end
            end
            dmq_pkg::ST_READ:
            begin
                state_next = dmq_pkg::ST_CMP;
            end
            dmq_pkg::ST_CMP:
            begin
                if (match)
                begin
                    state_next = more_search ? dmq_pkg::ST_SH_READ : dmq_pkg::ST_APPEND;
                end
                else if (more_search)
                begin
                    state_next = dmq_pkg::ST_READ;
                end
                else if (count_reg >= eff_cap && count_reg > dmq_pkg::CNT_W'(1))
                begin
                    state_next = dmq_pkg::ST_SH_READ;
                end
                else
                begin
                    state_next = dmq_pkg::ST_APPEND;
                end
            end
            dmq_pkg::ST_SH_READ:
            begin
                state_next = dmq_pkg::ST_SH_WRITE;
            end
            dmq_pkg::ST_SH_WRITE:
            begin
                state_next = more_shift ? dmq_pkg::ST_SH_READ : dmq_pkg::ST_APPEND;
            end
            dmq_pkg::ST_APPEND:
            begin
                state_next = dmq_pkg::ST_DONE;
            end
            dmq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = dmq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        mem_req.we      = 1'b0;
        mem_req.waddr   = idx_reg;
        mem_req.wdata   = rdata;
        mem_req.raddr   = idx_reg;
        key_next        = key_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        ev_next         = ev_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_hit_next    = out_hit_reg;
        out_hpos_next   = out_hpos_reg;
        out_ev_next     = out_ev_reg;
        out_evkey_next  = out_evkey_reg;
        out_occ_next    = out_occ_reg;

        case (state_reg)
            dmq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = request.key[dmq_pkg::KEY_BITS-1:0];
                    idx_next   = '0;
                    pos_next   = '0;
                    found_next = 1'b0;
                    ev_next    = 1'b0;
                end
            end
            dmq_pkg::ST_CMP:
            begin
                if (idx_reg == '0)
                begin
                    head_next = rdata;
                end
                if (match)
                begin
                    found_next = 1'b1;
                    pos_next   = idx_reg;
                    // Last entry hit: nothing to move up
                    if (!more_search)
                    begin
                        count_next = count_reg - dmq_pkg::CNT_W'(1);
                    end
                end
                else if (more_search)
                begin
                    idx_next = idx_reg + dmq_pkg::IDX_W'(1);
                end
                else if (count_reg >= eff_cap)
                begin
                    // Evict the head and close the gap from position zero
                    ev_next  = 1'b1;
                    idx_next = '0;
                    if (count_reg <= dmq_pkg::CNT_W'(1))
                    begin
                        count_next = count_reg - dmq_pkg::CNT_W'(1);
                    end
                end
            end
            dmq_pkg::ST_SH_READ:
            begin
                mem_req.raddr = dmq_pkg::IDX_W'(idx_inc);
            end
            dmq_pkg::ST_SH_WRITE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = rdata;
                if (more_shift)
                begin
                    idx_next = idx_reg + dmq_pkg::IDX_W'(1);
                end
                else
                begin
                    count_next = count_reg - dmq_pkg::CNT_W'(1);
                end
            end
            dmq_pkg::ST_APPEND:
            begin
                // Count is below the depth here after any removal
                mem_req.we    = 1'b1;
                mem_req.waddr = dmq_pkg::IDX_W'(count_reg);
                mem_req.wdata = key_reg;
                count_next    = count_reg + dmq_pkg::CNT_W'(1);
            end
            dmq_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = found_reg;
                    out_hpos_next  = dmq_pkg::HPOS_W'(pos_reg);
                    out_ev_next    = ev_reg;
                    out_evkey_next = ev_reg ? head_reg : '0;
                    out_occ_next   = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmq_pkg::ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= dmq_pkg::CAP_W'(dmq_pkg::CAP_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
        end
    end

    // Payload: hold between updates
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        head_reg      <= head_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        found_reg     <= found_next;
        ev_reg        <= ev_next;
        out_hit_reg   <= out_hit_next;
        out_hpos_reg  <= out_hpos_next;
        out_ev_reg    <= out_ev_next;
        out_evkey_reg <= out_evkey_next;
        out_occ_reg   <= out_occ_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.hit          = out_hit_reg;
    assign result.hit_position = out_hpos_reg;
    assign result.evicted      = out_ev_reg;
    assign result.evicted_key  = dmq_pkg::KEY_W'(out_evkey_reg);
    assign result.occupancy    = dmq_pkg::OCC_W'(out_occ_reg);

endmodule

`default_nettype wire

// ===== rtl/core/dmq_checker.sv =====
`default_nettype none

module dmq_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_valid,
    input wire logic                        req_ready,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire logic                        res_hit,
    input wire logic                        res_evicted,
    input wire logic [dmq_pkg::KEY_W-1:0]   res_evicted_key,
    input wire logic [dmq_pkg::OCC_W-1:0]   res_occupancy
);

    // Hold a pending result until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped before it was taken");

    // One request at a time: not ready right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in progress");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_occupancy != '0 && 32'(res_occupancy) <= dmq_pkg::DEPTH))
        else $error("occupancy out of range");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_hit |-> !res_evicted)
        else $error("hit reported together with an eviction");

    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_evicted |-> res_evicted_key == '0)
        else $error("evicted key nonzero without eviction");

endmodule

bind dedup_move_to_back_queue_unit dmq_checker u_dmq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (request.valid),
    .req_ready       (request.ready),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_hit         (result.hit),
    .res_evicted     (result.evicted),
    .res_evicted_key (result.evicted_key),
    .res_occupancy   (result.occupancy)
);

`default_nettype wire

// ===== bench/tb_dedup_move_to_back_queue_unit.sv =====
`default_nettype none

module tb_dedup_move_to_back_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let the block settle after the last result before a register
    // write or the end of the run.
    localparam int SETTLE_CYCLES = 4 * dmq_pkg::DEPTH + 8;
    // Cycles without any handshake before the run is abandoned.
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 152;

    typedef enum logic [1:0] {
        CMD_KEY,
        CMD_CFG,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct {
        cmd_kind_t                  kind;
        dmq_pkg::key_t              key;
        logic [dmq_pkg::CAP_W-1:0]  cap;
        int                         gap;
        logic                       calm;
    } stim_cmd_t;

    typedef struct packed {
        logic                       hit;
        logic [dmq_pkg::HPOS_W-1:0] hit_position;
        logic                       evicted;
        logic [dmq_pkg::KEY_W-1:0]  evicted_key;
        logic [dmq_pkg::OCC_W-1:0]  occupancy;
    } list_outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [dmq_pkg::CAP_W-1:0] cfg_write_data;

    dmq_req_if request_ch ();
    dmq_res_if result_ch ();

    dedup_move_to_back_queue_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .request        (request_ch),
        .result         (result_ch)
    );

    // Own copy of the recency list, head at index 0.
    dmq_pkg::key_t              list_keys [dmq_pkg::DEPTH];
    int                         list_cnt;
    logic [dmq_pkg::CAP_W-1:0]  list_cap;

    stim_cmd_t          stim_cmds [$];
    list_outcome_t      predicted_outcomes [$];

    // Driver bookkeeping
    stim_cmd_t          cur_cmd;
    logic               holding;
    logic               sending;
    logic               req_taken;
    logic               res_taken;
    logic               rx_calm;
    int                 res_wait;
    logic               phase_calm;

    int                 mismatches;
    int                 stall_cycles;

    // Look the key up, then remove the hit or the head and append at the tail.
    function automatic list_outcome_t refresh_list(input dmq_pkg::key_t key);
        list_outcome_t o;
        int cap;
        int pos;
        int drop;
        o    = '0;
        pos  = -1;
        drop = -1;
        // Zero means the full depth; anything past DEPTH saturates.
        cap = (list_cap == 0 || list_cap > dmq_pkg::DEPTH) ? dmq_pkg::DEPTH : int'(list_cap);
        for (int i = 0; i < list_cnt; i++)
        begin
            if (pos < 0 && list_keys[i] == key)
                pos = i;
        end
        if (pos >= 0)
        begin
            o.hit          = 1'b1;
            o.hit_position = pos[dmq_pkg::HPOS_W-1:0];
            drop           = pos;
        end
        else if (list_cnt >= cap && list_cnt > 0)
        begin
            // Only the head goes, even when the limit was lowered below the count.
            o.evicted     = 1'b1;
            o.evicted_key = list_keys[0];
            drop          = 0;
        end
        if (drop >= 0)
        begin
            for (int i = drop; i < list_cnt - 1; i++)
                list_keys[i] = list_keys[i + 1];
            list_cnt--;
        end
        if (list_cnt < dmq_pkg::DEPTH)
        begin
            list_keys[list_cnt] = key;
            list_cnt++;
        end
        o.occupancy = list_cnt[dmq_pkg::OCC_W-1:0];
        return o;
    endfunction

    task automatic add_key(input dmq_pkg::key_t key);
        stim_cmd_t c;
        c.kind = CMD_KEY;
        c.key  = key;
        c.cap  = '0;
        c.gap  = phase_calm ? 0 : $urandom_range(0, 9);
        c.calm = phase_calm;
        stim_cmds.push_back(c);
    endtask

    // Hold off until every result is back and the block has settled, then write.
    task automatic add_config(input logic [dmq_pkg::CAP_W-1:0] cap);
        stim_cmd_t c;
        c.kind = CMD_DRAIN;
        c.key  = '0;
        c.cap  = '0;
        c.gap  = SETTLE_CYCLES;
        c.calm = 1'b0;
        stim_cmds.push_back(c);
        c.kind = CMD_CFG;
        c.cap  = cap;
        c.gap  = 0;
        stim_cmds.push_back(c);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: act at the falling edge so every input is stable at the next
    // rising edge. Compute next values first and assign each signal once.
    always @(negedge clk)
    begin
        logic                       nxt_valid;
        dmq_pkg::key_t              nxt_key;
        logic                       nxt_we;
        logic [dmq_pkg::CAP_W-1:0]  nxt_data;
        logic                       nxt_ready;
        if (rst_n)
        begin
            nxt_valid = request_ch.valid;
            nxt_key   = request_ch.key;
            nxt_we    = 1'b0;
            nxt_data  = cfg_write_data;
            // Drop valid once the request went through, unless the next one follows at once.
            if (req_taken)
            begin
                req_taken = 1'b0;
                nxt_valid = 1'b0;
                sending   = 1'b0;
            end
            if (!sending)
            begin
                if (!holding && stim_cmds.size() > 0)
                begin
                    cur_cmd = stim_cmds.pop_front();
                    holding = 1'b1;
                end
                if (holding)
                begin
                    case (cur_cmd.kind)
                        CMD_KEY:
                        begin
                            if (cur_cmd.gap > 0)
                                cur_cmd.gap = cur_cmd.gap - 1;
                            else
                            begin
                                nxt_valid = 1'b1;
                                nxt_key   = cur_cmd.key;
                                sending   = 1'b1;
                                holding   = 1'b0;
                                rx_calm   = cur_cmd.calm;
                            end
                        end
                        CMD_CFG:
                        begin
                            nxt_we   = 1'b1;
                            nxt_data = cur_cmd.cap;
                            holding  = 1'b0;
                        end
                        default:
                        begin
                            // Wait for the last result, then count out the settle time.
                            if (predicted_outcomes.size() == 0)
                            begin
                                if (cur_cmd.gap > 0)
                                    cur_cmd.gap = cur_cmd.gap - 1;
                                else
                                    holding = 1'b0;
                            end
                        end
                    endcase
                end
            end
            // Receiver: draw a fresh stall after each result taken.
            if (res_taken)
            begin
                res_taken = 1'b0;
                res_wait  = rx_calm ? 0 : $urandom_range(0, 9);
            end
            if (res_wait > 0)
            begin
                res_wait  = res_wait - 1;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            request_ch.valid <= nxt_valid;
            request_ch.key   <= nxt_key;
            cfg_write_en     <= nxt_we;
            cfg_write_data   <= nxt_data;
            result_ch.ready  <= nxt_ready;
        end
    end

    // Monitor: sample at the rising edge, predict on each accepted request,
    // check each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        list_outcome_t want;
        logic progress;
        if (rst_n)
        begin
            progress = 1'b0;
            if (result_ch.valid && result_ch.ready)
            begin
                progress  = 1'b1;
                res_taken = 1'b1;
                if (predicted_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result with no request pending, expected none, actual %h",
                             $time, result_ch.evicted_key);
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    check_field("hit", 64'(want.hit), 64'(result_ch.hit));
                    check_field("hit_position", 64'(want.hit_position),
                                64'(result_ch.hit_position));
                    check_field("evicted", 64'(want.evicted), 64'(result_ch.evicted));
                    check_field("evicted_key", 64'(want.evicted_key),
                                64'(result_ch.evicted_key));
                    check_field("occupancy", 64'(want.occupancy), 64'(result_ch.occupancy));
                end
            end
            if (request_ch.valid && request_ch.ready)
            begin
                progress  = 1'b1;
                req_taken = 1'b1;
                predicted_outcomes.push_back(refresh_list(request_ch.key));
            end
            if (cfg_write_en)
                list_cap = cfg_write_data;
            if (progress)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        dmq_pkg::key_t pool [12];
        int   pool_n;
        logic [dmq_pkg::CAP_W-1:0] cap;

        rst_n             = 1'b0;
        request_ch.valid  = 1'b0;
        request_ch.key    = '0;
        result_ch.ready   = 1'b0;
        cfg_write_en      = 1'b0;
        cfg_write_data    = '0;
        holding           = 1'b0;
        sending           = 1'b0;
        req_taken         = 1'b0;
        res_taken         = 1'b0;
        rx_calm           = 1'b0;
        res_wait          = 0;
        phase_calm        = 1'b0;
        mismatches        = 0;
        stall_cycles      = 0;
        list_cnt          = 0;
        list_cap          = dmq_pkg::CAP_W'(dmq_pkg::CAP_RESET);
        for (int i = 0; i < dmq_pkg::DEPTH; i++)
            list_keys[i] = '0;

        // Directed part. The count never shrinks, so small limits only show
        // while the list is still filling: take them first.
        add_key('0);                            // reset limit, empty list
        add_config(4'd1);
        add_key('1);                            // full at one: evict the head
        add_key('1);                            // hit at the head
        add_config(4'd2);
        add_key(64'h0123_4567_89AB_CDEF);
        add_key(64'hFEDC_BA98_7654_3210);       // evict at the limit of two
        add_config(4'd0);                       // zero means the whole depth
        for (int i = 0; i < 6; i++)
            add_key(64'hA5A5_0000_0000_0000 | 64'(i));
        add_key(64'hA5A5_0000_0000_0005);       // hit at the tail
        add_key(64'h0123_4567_89AB_CDEF);       // hit at the head
        add_key(64'h8000_0000_0000_0001);       // miss on a full list
        add_config(4'd3);                       // limit below the count
        add_key(64'h5A5A_5A5A_5A5A_5A5A);       // only the head goes
        add_key(64'hA5A5_0000_0000_0002);       // hit in the middle
        add_config(4'd15);                      // beyond the depth saturates
        add_key(64'h7FFF_FFFF_FFFF_FFFE);

        // Random phases: a small pool of keys gives hits at every position,
        // fresh keys give misses and evictions.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       cap = 4'd8;
                1:       cap = 4'd0;
                2:       cap = 4'd15;
                3:       cap = 4'd1;
                default: cap = 4'($urandom_range(0, 15));
            endcase
            add_config(cap);
            phase_calm = ($urandom_range(0, 3) == 0);
            pool_n = $urandom_range(2, 12);
            for (int i = 0; i < pool_n; i++)
                pool[i] = {$urandom, $urandom};
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 75)
                    add_key(pool[$urandom_range(0, pool_n - 1)]);
                else
                    add_key({$urandom, $urandom});
            end
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Hold until every request went out and every result came back.
        while (stim_cmds.size() > 0 || holding || sending || predicted_outcomes.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (predicted_outcomes.size() > 0)
        begin
            mismatches++;
            $display("%0t ns: results missing, expected %0d more, actual 0",
                     $time, predicted_outcomes.size());
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== dedup_move_to_back_queue_unit.f =====
rtl/core/dmq_pkg.sv
rtl/core/dmq_if.sv
rtl/core/dmq_store.sv
rtl/core/dedup_move_to_back_queue_unit.sv
rtl/core/dmq_checker.sv
bench/tb_dedup_move_to_back_queue_unit.sv
